### rtl/efade_pkg.sv
package efade_pkg;

   localparam int LEVEL_FRAC_BITS = 15;
   localparam int LEVEL_W = 16;
   localparam int TIME_W = 32;
   localparam int DUR_W = 16;
   localparam int FRAC_W = 31;
   localparam int MUL_W = 32;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1 << LEVEL_FRAC_BITS);
   // A ramp only starts when the level gap times 10000 exceeds full scale.
   localparam logic [LEVEL_W-1:0] RAMP_MIN_DIFF = LEVEL_W'((1 << LEVEL_FRAC_BITS) / 10000);
   localparam logic [MUL_W-1:0] Q31_ONE = MUL_W'(64'd1 << FRAC_W);
   localparam logic [PROD_W-1:0] Q31_HALF = PROD_W'(64'd1 << (FRAC_W - 1));

   typedef logic [2:0] action_type;
   localparam action_type ACT_TICK   = 3'd0;
   localparam action_type ACT_OPEN   = 3'd1;
   localparam action_type ACT_CLOSE  = 3'd2;
   localparam action_type ACT_REVEAL = 3'd3;
   localparam action_type ACT_INIT   = 3'd4;
   localparam action_type ACT_TAKE   = 3'd5;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_OPEN_DUR    = 3'd0;
   localparam csr_index_type CSR_CLOSE_DUR   = 3'd1;
   localparam csr_index_type CSR_CONTENT_DUR = 3'd2;
   localparam csr_index_type CSR_CONTENT_LVL = 3'd3;
   localparam csr_index_type CSR_MAX_DUR     = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SAMPLE,
      S_CHECK,
      S_DIV,
      S_SQUARE,
      S_CUBE,
      S_SCALE,
      S_APPLY,
      S_ACT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] start;
      logic [LEVEL_W-1:0] goal;
      logic [LEVEL_W-1:0] now;
      logic [TIME_W-1:0]  t0;
      logic [DUR_W-1:0]   len;
      logic               active;
   } chan_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
      return (v > LEVEL_ONE) ? LEVEL_ONE : v;
   endfunction

   function automatic logic [DUR_W-1:0] ramp_length(input logic [DUR_W-1:0] dur,
                                                    input logic [DUR_W-1:0] max_dur);
      logic [DUR_W-1:0] hi;
      logic [DUR_W-1:0] d;
      hi = (max_dur == '0) ? DUR_W'(1) : max_dur;
      d = (dur == '0) ? DUR_W'(1) : dur;
      return (d > hi) ? hi : d;
   endfunction

   function automatic chan_type start_chan(input chan_type c,
                                           input logic [LEVEL_W-1:0] from,
                                           input logic [LEVEL_W-1:0] target,
                                           input logic [DUR_W-1:0] dur,
                                           input logic [DUR_W-1:0] max_dur,
                                           input logic rm,
                                           input logic [TIME_W-1:0] latest);
      chan_type r;
      logic [LEVEL_W-1:0] diff;
      r = c;
      r.start = clamp_level(from);
      r.goal = clamp_level(target);
      r.t0 = latest;
      r.len = rm ? '0 : ramp_length(dur, max_dur);
      diff = (r.goal >= r.start) ? (r.goal - r.start) : (r.start - r.goal);
      r.active = (r.len != '0) && (diff > RAMP_MIN_DIFF);
      r.now = r.active ? r.start : r.goal;
      return r;
   endfunction

endpackage

### rtl/efade_divider.sv
module efade_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [efade_pkg::DUR_W-1:0]     elapsed,
   input  logic [efade_pkg::DUR_W-1:0]     divisor,
   output logic                            done,
   output logic [efade_pkg::FRAC_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(efade_pkg::FRAC_W + 1);

   logic [efade_pkg::DUR_W:0]    rem_ff, rem_in;
   logic [efade_pkg::FRAC_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [efade_pkg::DUR_W:0]    shifted;
   logic                         fits;

   // One quotient bit per cycle; the remainder stays below the divisor as long as elapsed starts below it.
   always_comb begin
      shifted = {rem_ff[efade_pkg::DUR_W-1:0], 1'b0};
      fits = shifted >= {1'b0, divisor};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, elapsed};
         quo_in = '0;
         cnt_in = CNT_W'(efade_pkg::FRAC_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? (shifted - {1'b0, divisor}) : shifted;
         quo_in = {quo_ff[efade_pkg::FRAC_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         run_ff <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/efade_mul.sv
module efade_mul (
   input  logic                          clock,
   input  logic [efade_pkg::MUL_W-1:0]   mul_a,
   input  logic [efade_pkg::MUL_W-1:0]   mul_b,
   output logic [efade_pkg::PROD_W-1:0]  product
);

   logic [efade_pkg::PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = {{efade_pkg::MUL_W{1'b0}}, mul_a} * {{efade_pkg::MUL_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

### rtl/eased_fade_timeline.sv
// Two-channel opacity fade engine (shell and content) in Q1.15.
// Input words carry an action, a millisecond timestamp and a reduced-motion
// flag; each accepted word yields exactly one result word with both levels,
// the ramping flags and the hide-done flags as they stand after the action.
// Channels use valid/stall: a word moves on a clock edge with valid high and
// stall low. req_stall is high from acceptance until the result word has
// been taken, so one word is in flight at a time.
// After acceptance each channel gets a check, which is skipped with reduced
// motion; a ramping channel then runs the restoring divider (31 quotient
// bits and the done flag), the square, cube and scale passes through the
// shared 32x32 multiplier and the update, before the action and the result.
// The result stays in an output register while rsp_stall is high; the next
// word is accepted once it has been taken.
// Configuration writes on the csr_ port take effect at once and must only be
// done while the block is idle. Synchronous reset restores the register
// defaults, hides the shell and shows the content fully, with no ramp.
module eased_fade_timeline (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_action,
   input  logic [efade_pkg::TIME_W-1:0]      req_timestamp_ms,
   input  logic                              req_reduced_motion,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [efade_pkg::LEVEL_W-1:0]     rsp_shell_level,
   output logic [efade_pkg::LEVEL_W-1:0]     rsp_content_level,
   output logic                              rsp_any_ramping,
   output logic                              rsp_shell_ramping,
   output logic                              rsp_content_ramping,
   output logic                              rsp_hide_done,
   output logic                              rsp_hide_pending,
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [efade_pkg::DUR_W-1:0]       csr_wdata
);

   localparam int LW = efade_pkg::LEVEL_W;
   localparam int DW = efade_pkg::DUR_W;
   localparam int TW = efade_pkg::TIME_W;
   localparam int MW = efade_pkg::MUL_W;
   localparam int FW = efade_pkg::FRAC_W;

   efade_pkg::state_type state_ff, state_in;

   logic [DW-1:0] open_dur_ff, close_dur_ff, content_dur_ff, content_lvl_ff, max_dur_ff;

   logic [TW-1:0]         latest_ff, latest_in;
   efade_pkg::chan_type   sh_ff, sh_in, ct_ff, ct_in;
   logic                  sh_ease_in_ff, sh_ease_in_in;
   logic                  close_req_ff, close_req_in;
   logic                  hide_ready_ff, hide_ready_in;
   efade_pkg::action_type action_ff, action_in;
   logic [TW-1:0]         ts_ff, ts_in;
   logic                  rm_ff, rm_in;
   logic                  ch_ff, ch_in;
   logic [MW-1:0]         x_ff, x_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] rsp_shell_ff, rsp_shell_in, rsp_content_ff, rsp_content_in;
   logic          rsp_sh_ramp_ff, rsp_sh_ramp_in, rsp_ct_ramp_ff, rsp_ct_ramp_in;
   logic          rsp_done_ff, rsp_done_in, rsp_pend_ff, rsp_pend_in;

   efade_pkg::chan_type cur;
   logic                cur_ease;
   logic [TW-1:0]       elapsed_full;
   logic                finished;
   logic                skip;
   logic [LW-1:0]       diff;
   logic [MW-1:0]       cube_part;
   logic [MW-1:0]       ease_p;
   logic [efade_pkg::PROD_W-1:0] rounded;
   logic [LW-1:0]       mag;

   logic                         div_start;
   logic                         div_done;
   logic [FW-1:0]                div_q;
   logic [MW-1:0]                mul_a, mul_b;
   logic [efade_pkg::PROD_W-1:0] product;

   efade_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .elapsed  (elapsed_full[DW-1:0]),
      .divisor  (cur.len),
      .done     (div_done),
      .quotient (div_q)
   );

   efade_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_dur_ff <= DW'(200);
         close_dur_ff <= DW'(150);
         content_dur_ff <= DW'(150);
         content_lvl_ff <= DW'(29491);
         max_dur_ff <= DW'(2000);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            efade_pkg::CSR_OPEN_DUR:    open_dur_ff <= csr_wdata;
            efade_pkg::CSR_CLOSE_DUR:   close_dur_ff <= csr_wdata;
            efade_pkg::CSR_CONTENT_DUR: content_dur_ff <= csr_wdata;
            efade_pkg::CSR_CONTENT_LVL: content_lvl_ff <= csr_wdata;
            efade_pkg::CSR_MAX_DUR:     max_dur_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Channel under work and the shared arithmetic around it.
   always_comb begin
      cur = ch_ff ? ct_ff : sh_ff;
      cur_ease = ch_ff ? 1'b0 : sh_ease_in_ff;
      elapsed_full = (latest_ff >= cur.t0) ? (latest_ff - cur.t0) : '0;
      finished = elapsed_full >= {{(TW-DW){1'b0}}, cur.len};
      skip = !cur.active || (cur.len == '0);
      diff = (cur.goal >= cur.start) ? (cur.goal - cur.start) : (cur.start - cur.goal);
      cube_part = product[FW+MW-1:FW];
      ease_p = cur_ease ? cube_part : (efade_pkg::Q31_ONE - cube_part);
      rounded = product + efade_pkg::Q31_HALF;
      mag = rounded[FW+LW-1:FW];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efade_pkg::S_IDLE:   if (req_valid) state_in = efade_pkg::S_SAMPLE;
         efade_pkg::S_SAMPLE: state_in = rm_ff ? efade_pkg::S_ACT : efade_pkg::S_CHECK;
         efade_pkg::S_CHECK: begin
            if (skip || finished) begin
               state_in = ch_ff ? efade_pkg::S_ACT : efade_pkg::S_CHECK;
            end else begin
               state_in = efade_pkg::S_DIV;
            end
         end
         efade_pkg::S_DIV:    if (div_done) state_in = efade_pkg::S_SQUARE;
         efade_pkg::S_SQUARE: state_in = efade_pkg::S_CUBE;
         efade_pkg::S_CUBE:   state_in = efade_pkg::S_SCALE;
         efade_pkg::S_SCALE:  state_in = efade_pkg::S_APPLY;
         efade_pkg::S_APPLY:  state_in = ch_ff ? efade_pkg::S_ACT : efade_pkg::S_CHECK;
         efade_pkg::S_ACT:    state_in = efade_pkg::S_OUT;
         efade_pkg::S_OUT:    if (!rsp_stall) state_in = efade_pkg::S_IDLE;
         default:             state_in = efade_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = state_ff != efade_pkg::S_IDLE;
      div_start = (state_ff == efade_pkg::S_CHECK) && !skip && !finished;
      mul_a = x_ff;
      mul_b = x_ff;
      unique case (state_ff)
         efade_pkg::S_CUBE: begin
            mul_a = cube_part;
            mul_b = x_ff;
         end
         efade_pkg::S_SCALE: begin
            mul_a = {{(MW-LW){1'b0}}, diff};
            mul_b = ease_p;
         end
         default: ;
      endcase
   end

   // Datapath updates.
   always_comb begin
      efade_pkg::chan_type upd;
      efade_pkg::chan_type s, c;
      logic                se, cr, hr, taken;
      logic [LW-1:0]       from;

      latest_in = latest_ff;
      sh_in = sh_ff;
      ct_in = ct_ff;
      sh_ease_in_in = sh_ease_in_ff;
      close_req_in = close_req_ff;
      hide_ready_in = hide_ready_ff;
      action_in = action_ff;
      ts_in = ts_ff;
      rm_in = rm_ff;
      ch_in = ch_ff;
      x_in = x_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_shell_in = rsp_shell_ff;
      rsp_content_in = rsp_content_ff;
      rsp_sh_ramp_in = rsp_sh_ramp_ff;
      rsp_ct_ramp_in = rsp_ct_ramp_ff;
      rsp_done_in = rsp_done_ff;
      rsp_pend_in = rsp_pend_ff;
      upd = cur;
      s = sh_ff;
      c = ct_ff;
      se = sh_ease_in_ff;
      cr = close_req_ff;
      hr = hide_ready_ff;
      taken = 1'b0;
      from = '0;

      case (state_ff)
         efade_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in = req_action;
               ts_in = req_timestamp_ms;
               rm_in = req_reduced_motion;
            end
         end
         efade_pkg::S_SAMPLE: begin
            if (ts_ff > latest_ff) latest_in = ts_ff;
            ch_in = 1'b0;
            if (rm_ff) begin
               sh_in.now = sh_ff.goal;
               sh_in.start = sh_ff.goal;
               sh_in.len = '0;
               sh_in.active = 1'b0;
               ct_in.now = ct_ff.goal;
               ct_in.start = ct_ff.goal;
               ct_in.len = '0;
               ct_in.active = 1'b0;
            end
         end
         efade_pkg::S_CHECK: begin
            if (!skip && finished) begin
               upd.now = cur.goal;
               upd.start = cur.goal;
               upd.active = 1'b0;
               if (ch_ff) ct_in = upd;
               else sh_in = upd;
            end
            if (skip || finished) ch_in = 1'b1;
         end
         efade_pkg::S_DIV: begin
            if (div_done) begin
               x_in = cur_ease ? {1'b0, div_q} : (efade_pkg::Q31_ONE - {1'b0, div_q});
            end
         end
         efade_pkg::S_APPLY: begin
            upd.now = (cur.goal >= cur.start) ? (cur.start + mag) : (cur.start - mag);
            if (ch_ff) ct_in = upd;
            else sh_in = upd;
            ch_in = 1'b1;
         end
         efade_pkg::S_ACT: begin
            // A finished close at zero turns into a pending hide.
            if (cr && !s.active && (s.goal == '0)) begin
               s.now = '0;
               cr = 1'b0;
               hr = 1'b1;
            end
            case (action_ff)
               efade_pkg::ACT_OPEN: begin
                  cr = 1'b0;
                  hr = 1'b0;
                  se = 1'b0;
                  s = efade_pkg::start_chan(s, s.now, efade_pkg::LEVEL_ONE, open_dur_ff,
                                            max_dur_ff, rm_ff, latest_ff);
               end
               efade_pkg::ACT_CLOSE: begin
                  cr = 1'b1;
                  hr = 1'b0;
                  c.start = efade_pkg::LEVEL_ONE;
                  c.goal = efade_pkg::LEVEL_ONE;
                  c.now = efade_pkg::LEVEL_ONE;
                  c.len = '0;
                  c.active = 1'b0;
                  se = 1'b1;
                  s = efade_pkg::start_chan(s, s.now, '0, close_dur_ff,
                                            max_dur_ff, rm_ff, latest_ff);
                  if (!s.active && (s.goal == '0)) begin
                     s.now = '0;
                     cr = 1'b0;
                     hr = 1'b1;
                  end
               end
               efade_pkg::ACT_REVEAL: begin
                  from = c.active ? c.now : content_lvl_ff;
                  c = efade_pkg::start_chan(c, from, efade_pkg::LEVEL_ONE, content_dur_ff,
                                            max_dur_ff, rm_ff, latest_ff);
               end
               efade_pkg::ACT_INIT: begin
                  s.start = '0;
                  s.goal = '0;
                  s.now = '0;
                  s.len = '0;
                  s.active = 1'b0;
                  cr = 1'b0;
                  hr = 1'b0;
               end
               efade_pkg::ACT_TAKE: begin
                  taken = hr;
                  hr = 1'b0;
               end
               default: ;
            endcase
            sh_in = s;
            ct_in = c;
            sh_ease_in_in = se;
            close_req_in = cr;
            hide_ready_in = hr;
            rsp_valid_in = 1'b1;
            rsp_shell_in = s.now;
            rsp_content_in = c.now;
            rsp_sh_ramp_in = s.active;
            rsp_ct_ramp_in = c.active;
            rsp_done_in = taken;
            rsp_pend_in = hr;
         end
         efade_pkg::S_OUT: begin
            if (!rsp_stall) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efade_pkg::S_IDLE;
         latest_ff <= '0;
         sh_ff <= '0;
         ct_ff <= '{start: efade_pkg::LEVEL_ONE, goal: efade_pkg::LEVEL_ONE,
                    now: efade_pkg::LEVEL_ONE, t0: '0, len: '0, active: 1'b0};
         sh_ease_in_ff <= 1'b0;
         close_req_ff <= 1'b0;
         hide_ready_ff <= 1'b0;
         ch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         latest_ff <= latest_in;
         sh_ff <= sh_in;
         ct_ff <= ct_in;
         sh_ease_in_ff <= sh_ease_in_in;
         close_req_ff <= close_req_in;
         hide_ready_ff <= hide_ready_in;
         ch_ff <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      ts_ff <= ts_in;
      rm_ff <= rm_in;
      x_ff <= x_in;
      rsp_shell_ff <= rsp_shell_in;
      rsp_content_ff <= rsp_content_in;
      rsp_sh_ramp_ff <= rsp_sh_ramp_in;
      rsp_ct_ramp_ff <= rsp_ct_ramp_in;
      rsp_done_ff <= rsp_done_in;
      rsp_pend_ff <= rsp_pend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_shell_level = rsp_shell_ff;
   assign rsp_content_level = rsp_content_ff;
   assign rsp_any_ramping = rsp_sh_ramp_ff | rsp_ct_ramp_ff;
   assign rsp_shell_ramping = rsp_sh_ramp_ff;
   assign rsp_content_ramping = rsp_ct_ramp_ff;
   assign rsp_hide_done = rsp_done_ff;
   assign rsp_hide_pending = rsp_pend_ff;

endmodule

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 900000;
   localparam logic [63:0] Q31 = 64'd1 << 31;

   typedef struct packed {
      logic [15:0] shell;
      logic [15:0] content;
      logic        any_ramp;
      logic        shell_ramp;
      logic        content_ramp;
      logic        done;
      logic        pending;
   } fade_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic [31:0] req_timestamp_ms = '0;
   logic req_reduced_motion = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_shell_level, rsp_content_level;
   logic rsp_any_ramping, rsp_shell_ramping, rsp_content_ramping;
   logic rsp_hide_done, rsp_hide_pending;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   eased_fade_timeline dut (.*);

   always #10 clock = ~clock;

   // Predictor state.
   logic [15:0] open_dur, close_dur, content_dur, content_lvl, max_dur;
   logic [31:0] now_ms;
   logic [15:0] sh_start, sh_goal, sh_now, sh_len;
   logic [31:0] sh_t0;
   logic sh_in, sh_act;
   logic [15:0] ct_start, ct_goal, ct_now, ct_len;
   logic [31:0] ct_t0;
   logic ct_act, close_req, hide_flag;

   fade_out_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit hold_rsp = 0;
   bit noisy_rsp = 1;
   int gap_max = 3;
   logic [31:0] clock_ms;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [63:0] cube31(input logic [63:0] x);
      return (((x * x) >> 31) * x) >> 31;
   endfunction

   function automatic logic [15:0] lvl_clamp(input logic [15:0] v);
      return v > 16'd32768 ? 16'd32768 : v;
   endfunction

   function automatic void advance(inout logic [15:0] st, input logic [15:0] goal,
                                   inout logic [15:0] cur, input logic [31:0] t0,
                                   input logic [15:0] len, input logic ease_in,
                                   inout logic act);
      logic [63:0] el, lin, p, diff, mag;
      if (!act || len == 0) return;
      el = now_ms >= t0 ? 64'(now_ms - t0) : 64'd0;
      if (el >= len) begin
         cur = goal; st = goal; act = 0;
         return;
      end
      lin = (el << 31) / len;
      p = ease_in ? cube31(lin) : Q31 - cube31(Q31 - lin);
      diff = goal >= st ? 64'(goal - st) : 64'(st - goal);
      mag = (diff * p + (Q31 >> 1)) >> 31;
      cur = goal >= st ? st + 16'(mag) : st - 16'(mag);
   endfunction

   function automatic void begin_ramp(output logic [15:0] st, output logic [15:0] goal,
                                      output logic [15:0] cur, output logic [31:0] t0,
                                      output logic [15:0] len, input logic [15:0] from,
                                      input logic [15:0] target, input logic [15:0] dur,
                                      input logic rm, output logic act);
      logic [15:0] hi, d, diff;
      st = lvl_clamp(from);
      goal = lvl_clamp(target);
      t0 = now_ms;
      hi = max_dur == 0 ? 16'd1 : max_dur;
      d = dur == 0 ? 16'd1 : dur;
      len = rm ? 16'd0 : (d > hi ? hi : d);
      diff = goal >= st ? goal - st : st - goal;
      act = len != 0 && 32'(diff) * 10000 > 32'd32768;
      cur = act ? st : goal;
   endfunction

   function automatic void finish_close();
      if (!close_req || sh_act || sh_goal != 0) return;
      sh_now = 0; close_req = 0; hide_flag = 1;
   endfunction

   task automatic fade_reset();
      open_dur = 200; close_dur = 150; content_dur = 150; content_lvl = 29491; max_dur = 2000;
      now_ms = 0;
      sh_start = 0; sh_goal = 0; sh_now = 0; sh_t0 = 0; sh_len = 0; sh_in = 0; sh_act = 0;
      ct_start = 16'd32768; ct_goal = 16'd32768; ct_now = 16'd32768;
      ct_t0 = 0; ct_len = 0; ct_act = 0; close_req = 0; hide_flag = 0;
   endtask

   function automatic fade_out_type fade_step(input logic [2:0] act, input logic [31:0] ts,
                                              input logic rm);
      fade_out_type r;
      logic taken;
      logic [15:0] from;
      taken = 0;
      if (ts > now_ms) now_ms = ts;
      if (rm) begin
         sh_now = sh_goal; sh_start = sh_goal; sh_len = 0; sh_act = 0;
         ct_now = ct_goal; ct_start = ct_goal; ct_len = 0; ct_act = 0;
      end else begin
         advance(sh_start, sh_goal, sh_now, sh_t0, sh_len, sh_in, sh_act);
         advance(ct_start, ct_goal, ct_now, ct_t0, ct_len, 1'b0, ct_act);
      end
      finish_close();
      case (act)
         efade_pkg::ACT_OPEN: begin
            close_req = 0; hide_flag = 0; sh_in = 0;
            begin_ramp(sh_start, sh_goal, sh_now, sh_t0, sh_len, sh_now,
                       efade_pkg::LEVEL_ONE, open_dur, rm, sh_act);
         end
         efade_pkg::ACT_CLOSE: begin
            close_req = 1; hide_flag = 0;
            ct_start = efade_pkg::LEVEL_ONE; ct_goal = efade_pkg::LEVEL_ONE;
            ct_now = efade_pkg::LEVEL_ONE;
            ct_len = 0; ct_act = 0; sh_in = 1;
            begin_ramp(sh_start, sh_goal, sh_now, sh_t0, sh_len, sh_now, 16'd0,
                       close_dur, rm, sh_act);
            finish_close();
         end
         efade_pkg::ACT_REVEAL: begin
            from = ct_act ? ct_now : content_lvl;
            begin_ramp(ct_start, ct_goal, ct_now, ct_t0, ct_len, from,
                       efade_pkg::LEVEL_ONE, content_dur, rm, ct_act);
         end
         efade_pkg::ACT_INIT: begin
            sh_start = 0; sh_goal = 0; sh_now = 0; sh_len = 0; sh_act = 0;
            close_req = 0; hide_flag = 0;
         end
         efade_pkg::ACT_TAKE: begin
            taken = hide_flag; hide_flag = 0;
         end
         default: ;
      endcase
      r.shell = sh_now; r.content = ct_now;
      r.any_ramp = sh_act | ct_act; r.shell_ramp = sh_act; r.content_ramp = ct_act;
      r.done = taken; r.pending = hide_flag;
      return r;
   endfunction

   task automatic send_word(input logic [2:0] act, input logic [31:0] ts, input logic rm);
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, gap_max + 1);
      repeat (g) @(negedge clock);
      req_valid <= 1; req_action <= act; req_timestamp_ms <= ts; req_reduced_motion <= rm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(fade_step(act, ts, rm));
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(input efade_pkg::csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      case (idx)
         efade_pkg::CSR_OPEN_DUR:    open_dur = val;
         efade_pkg::CSR_CLOSE_DUR:   close_dur = val;
         efade_pkg::CSR_CONTENT_DUR: content_dur = val;
         efade_pkg::CSR_CONTENT_LVL: content_lvl = val;
         efade_pkg::CSR_MAX_DUR:     max_dur = val;
         default: ;
      endcase
   endtask

   // Checker.
   always @(posedge clock) begin
      fade_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("unexpected result word at %0t", $realtime);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_shell_level !== e.shell)
               report("shell_level", 32'(rsp_shell_level), 32'(e.shell));
            if (rsp_content_level !== e.content)
               report("content_level", 32'(rsp_content_level), 32'(e.content));
            if (rsp_any_ramping !== e.any_ramp)
               report("any_ramping", 32'(rsp_any_ramping), 32'(e.any_ramp));
            if (rsp_shell_ramping !== e.shell_ramp)
               report("shell_ramping", 32'(rsp_shell_ramping), 32'(e.shell_ramp));
            if (rsp_content_ramping !== e.content_ramp)
               report("content_ramping", 32'(rsp_content_ramping), 32'(e.content_ramp));
            if (rsp_hide_done !== e.done)
               report("hide_done", 32'(rsp_hide_done), 32'(e.done));
            if (rsp_hide_pending !== e.pending)
               report("hide_pending", 32'(rsp_hide_pending), 32'(e.pending));
         end
      end
   end

   // Receiver stalls.
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1;
      else if (noisy_rsp)
         rsp_stall <= ($urandom_range(0, 49) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
      else rsp_stall <= 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout");
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic test_directed();
      logic [2:0] a;
      clock_ms = 1000;
      send_word(efade_pkg::ACT_TICK, 32'd0, 0);
      send_word(efade_pkg::ACT_OPEN, clock_ms, 0);
      send_word(efade_pkg::ACT_TICK, clock_ms + 50, 0);
      send_word(efade_pkg::ACT_REVEAL, clock_ms + 60, 0);
      send_word(efade_pkg::ACT_TICK, clock_ms + 10, 0);      // time going backwards
      send_word(efade_pkg::ACT_TICK, clock_ms + 250, 0);
      send_word(efade_pkg::ACT_CLOSE, clock_ms + 300, 0);
      send_word(efade_pkg::ACT_TICK, clock_ms + 400, 0);
      send_word(efade_pkg::ACT_TICK, clock_ms + 460, 0);
      send_word(efade_pkg::ACT_TAKE, clock_ms + 461, 0);
      send_word(efade_pkg::ACT_TAKE, clock_ms + 462, 0);
      send_word(efade_pkg::ACT_OPEN, clock_ms + 500, 1);
      send_word(efade_pkg::ACT_CLOSE, clock_ms + 501, 1);
      send_word(efade_pkg::ACT_TAKE, clock_ms + 502, 0);
      send_word(efade_pkg::ACT_OPEN, clock_ms + 600, 0);
      send_word(efade_pkg::ACT_INIT, clock_ms + 610, 0);
      send_word(3'd6, clock_ms + 620, 0);
      send_word(3'd7, 32'hFFFF_FFFF, 1);
      a = efade_pkg::ACT_REVEAL;
      send_word(a, 32'hFFFF_FFFF, 0);
      wait_drained();
   endtask

   task automatic random_phase(input int count);
      logic [2:0] a;
      logic [31:0] ts;
      int r;
      clock_ms = now_ms;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) a = efade_pkg::ACT_TICK;
         else if (r < 48) a = efade_pkg::ACT_OPEN;
         else if (r < 64) a = efade_pkg::ACT_CLOSE;
         else if (r < 78) a = efade_pkg::ACT_REVEAL;
         else if (r < 84) a = efade_pkg::ACT_INIT;
         else if (r < 96) a = efade_pkg::ACT_TAKE;
         else a = 3'($urandom_range(6, 7));
         r = $urandom_range(0, 99);
         if (r < 3) ts = $urandom;
         else if (r < 8) ts = clock_ms - $urandom_range(0, 500);
         else begin
            clock_ms = clock_ms + $urandom_range(0, 120);
            ts = clock_ms;
         end
         send_word(a, ts, $urandom_range(0, 9) == 0);
      end
      wait_drained();
   endtask

   task automatic test_configs();
      write_reg(efade_pkg::CSR_MAX_DUR, 16'd0);
      random_phase(60);
      write_reg(efade_pkg::CSR_OPEN_DUR, 16'd65535);
      write_reg(efade_pkg::CSR_CLOSE_DUR, 16'd1);
      write_reg(efade_pkg::CSR_CONTENT_DUR, 16'd0);
      write_reg(efade_pkg::CSR_CONTENT_LVL, 16'd0);
      write_reg(efade_pkg::CSR_MAX_DUR, 16'd65535);
      random_phase(150);
      write_reg(efade_pkg::CSR_OPEN_DUR, 16'd1);
      write_reg(efade_pkg::CSR_CLOSE_DUR, 16'd65535);
      write_reg(efade_pkg::CSR_CONTENT_DUR, 16'd300);
      write_reg(efade_pkg::CSR_CONTENT_LVL, 16'hFFFF);
      write_reg(efade_pkg::CSR_MAX_DUR, 16'd400);
      random_phase(150);
      write_reg(efade_pkg::CSR_CONTENT_LVL, 16'd32768);
      write_reg(3'd7, 16'd5);
      random_phase(60);
      repeat (20) begin
         write_reg(efade_pkg::CSR_OPEN_DUR, 16'($urandom_range(0, 500)));
         write_reg(efade_pkg::CSR_CLOSE_DUR, 16'($urandom_range(0, 500)));
         write_reg(efade_pkg::CSR_CONTENT_DUR, 16'($urandom_range(0, 500)));
         write_reg(efade_pkg::CSR_CONTENT_LVL,
                   16'($urandom_range(0, 32767) | ($urandom_range(0, 1) << 15)));
         write_reg(efade_pkg::CSR_MAX_DUR, 16'($urandom));
         random_phase(25);
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         begin
            gap_max = 0;
            random_phase(40);
            gap_max = 3;
         end
      join
      noisy_rsp = 0;
      random_phase(10);
      noisy_rsp = 1;
   endtask

   initial begin
      fade_reset();
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_directed();
      test_backpressure();
      test_configs();
      wait_drained();
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule

### sim.f
rtl/efade_pkg.sv
rtl/efade_divider.sv
rtl/efade_mul.sv
rtl/eased_fade_timeline.sv
sim/testbench.sv
